/* src/sae_pkg.sv */
// shared constants, types and command codes for the suffix automaton engine
package sae_pkg;

	localparam int MAX_TEXT  = 4096;
	localparam int ALPHABET  = 26;
	localparam int STATE_CAP = 2 * MAX_TEXT;
	localparam int SW        = $clog2(STATE_CAP);      // state index
	localparam int TW        = $clog2(STATE_CAP + 1);  // state total
	localparam int LW        = $clog2(MAX_TEXT + 1);   // length and count
	localparam int SYMW      = 5;
	localparam int KW        = $clog2(ALPHABET + 1);
	localparam int TR_DEPTH  = STATE_CAP * (2 ** SYMW);
	localparam int H_DEPTH   = MAX_TEXT + 1;
	localparam int HAW       = $clog2(H_DEPTH);
	localparam int RW        = 24;
	localparam int OPW       = 3;

	typedef enum logic [OPW-1:0] {
		OP_CLEAR    = 3'd0,
		OP_APPEND   = 3'd1,
		OP_FINALIZE = 3'd2,
		OP_DISTINCT = 3'd3,
		OP_QUERY    = 3'd4
	} op_t;

	typedef enum logic [5:0] {
		CMD_NOP, CMD_ACCEPT, CMD_CLR_ZERO, CMD_APP_CHK, CMD_APP_ZERO,
		CMD_W_RD, CMD_W_EVAL, CMD_W_LEN, CMD_COPY, CMD_R_RD, CMD_R_EVAL,
		CMD_LINK_Q, CMD_LINK_CUR, CMD_F_HCLR, CMD_F_A_RD, CMD_F_A_HRD,
		CMD_F_A_HWR, CMD_F_P_RD, CMD_F_P_WR, CMD_F_S_RD, CMD_F_S_HRD,
		CMD_F_S_WR, CMD_F_U_RD, CMD_F_U_EVAL, CMD_F_U_OCC, CMD_F_U_WR,
		CMD_D_CHK, CMD_D_RD, CMD_D_LINK, CMD_D_ADD, CMD_Q_STEP, CMD_Q_EVAL,
		CMD_Q_OCC, CMD_Q_DONE, CMD_RESP
	} cmd_t;

	typedef enum logic [5:0] {
		ST_INIT, ST_IDLE, ST_CLR, ST_APP_CHK, ST_APP_ZERO, ST_W1, ST_W2, ST_W3,
		ST_COPY, ST_R1, ST_R2, ST_FIN1, ST_FIN2, ST_F_HCLR, ST_F_A1, ST_F_A2,
		ST_F_A3, ST_F_P1, ST_F_P2, ST_F_S1, ST_F_S2, ST_F_S3, ST_F_U1, ST_F_U2,
		ST_F_U3, ST_F_U4, ST_D_CHK, ST_D1, ST_D2, ST_D3, ST_Q1, ST_Q2, ST_Q3,
		ST_Q4, ST_RESP
	} state_t;

	typedef struct packed {
		logic k_last;
		logic copy_done;
		logic sym_bad;
		logic full;
		logic t_zero;
		logic p_zero;
		logic solid;
		logic hit;
		logic at_top;
		logic last_tot;
		logic v_zero;
		logic u_last;
		logic missed;
		logic last;
		logic out_free;
	} dp_status_t;

endpackage

/* src/sae_ram.sv */
// generic single write port ram with one registered read port
module sae_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/sae_ctrl.sv */
// controller state machine sequencing clear, append, finalize, distinct and query
module sae_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [sae_pkg::OPW-1:0] operation,
	input  sae_pkg::dp_status_t    st,
	output sae_pkg::cmd_t          cmd
);

	sae_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sae_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = sae_pkg::CMD_NOP;
		in_stall = 1'b1;
		case (state_q)
			sae_pkg::ST_INIT: begin
				cmd = sae_pkg::CMD_CLR_ZERO;
				if (st.k_last) state_d = sae_pkg::ST_IDLE;
			end
			sae_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd = sae_pkg::CMD_ACCEPT;
					case (operation)
						sae_pkg::OP_CLEAR:    state_d = sae_pkg::ST_CLR;
						sae_pkg::OP_APPEND:   state_d = sae_pkg::ST_APP_CHK;
						sae_pkg::OP_FINALIZE: state_d = sae_pkg::ST_F_HCLR;
						sae_pkg::OP_DISTINCT: state_d = sae_pkg::ST_D_CHK;
						sae_pkg::OP_QUERY:    state_d = sae_pkg::ST_Q1;
						default:              state_d = sae_pkg::ST_IDLE;
					endcase
				end
			end
			sae_pkg::ST_CLR: begin
				cmd = sae_pkg::CMD_CLR_ZERO;
				if (st.k_last) state_d = sae_pkg::ST_RESP;
			end
			sae_pkg::ST_APP_CHK: begin
				cmd = sae_pkg::CMD_APP_CHK;
				state_d = (st.sym_bad || st.full) ? sae_pkg::ST_RESP : sae_pkg::ST_APP_ZERO;
			end
			sae_pkg::ST_APP_ZERO: begin
				cmd = sae_pkg::CMD_APP_ZERO;
				if (st.k_last) state_d = sae_pkg::ST_W1;
			end
			sae_pkg::ST_W1: begin
				cmd = sae_pkg::CMD_W_RD;
				state_d = sae_pkg::ST_W2;
			end
			sae_pkg::ST_W2: begin
				cmd = sae_pkg::CMD_W_EVAL;
				if (!st.t_zero) state_d = sae_pkg::ST_W3;
				else if (st.p_zero) state_d = sae_pkg::ST_RESP;
				else state_d = sae_pkg::ST_W1;
			end
			sae_pkg::ST_W3: begin
				cmd = sae_pkg::CMD_W_LEN;
				state_d = st.solid ? sae_pkg::ST_RESP : sae_pkg::ST_COPY;
			end
			sae_pkg::ST_COPY: begin
				cmd = sae_pkg::CMD_COPY;
				if (st.copy_done) state_d = sae_pkg::ST_R1;
			end
			sae_pkg::ST_R1: begin
				cmd = sae_pkg::CMD_R_RD;
				state_d = sae_pkg::ST_R2;
			end
			sae_pkg::ST_R2: begin
				cmd = sae_pkg::CMD_R_EVAL;
				state_d = (st.hit && !st.p_zero) ? sae_pkg::ST_R1 : sae_pkg::ST_FIN1;
			end
			sae_pkg::ST_FIN1: begin
				cmd = sae_pkg::CMD_LINK_Q;
				state_d = sae_pkg::ST_FIN2;
			end
			sae_pkg::ST_FIN2: begin
				cmd = sae_pkg::CMD_LINK_CUR;
				state_d = sae_pkg::ST_RESP;
			end
			sae_pkg::ST_F_HCLR: begin
				cmd = sae_pkg::CMD_F_HCLR;
				if (st.at_top) state_d = sae_pkg::ST_F_A1;
			end
			sae_pkg::ST_F_A1: begin
				cmd = sae_pkg::CMD_F_A_RD;
				state_d = sae_pkg::ST_F_A2;
			end
			sae_pkg::ST_F_A2: begin
				cmd = sae_pkg::CMD_F_A_HRD;
				state_d = sae_pkg::ST_F_A3;
			end
			sae_pkg::ST_F_A3: begin
				cmd = sae_pkg::CMD_F_A_HWR;
				state_d = st.last_tot ? sae_pkg::ST_F_P1 : sae_pkg::ST_F_A1;
			end
			sae_pkg::ST_F_P1: begin
				cmd = sae_pkg::CMD_F_P_RD;
				state_d = sae_pkg::ST_F_P2;
			end
			sae_pkg::ST_F_P2: begin
				cmd = sae_pkg::CMD_F_P_WR;
				state_d = st.at_top ? sae_pkg::ST_F_S1 : sae_pkg::ST_F_P1;
			end
			sae_pkg::ST_F_S1: begin
				cmd = sae_pkg::CMD_F_S_RD;
				state_d = sae_pkg::ST_F_S2;
			end
			sae_pkg::ST_F_S2: begin
				cmd = sae_pkg::CMD_F_S_HRD;
				state_d = sae_pkg::ST_F_S3;
			end
			sae_pkg::ST_F_S3: begin
				cmd = sae_pkg::CMD_F_S_WR;
				state_d = st.last_tot ? sae_pkg::ST_F_U1 : sae_pkg::ST_F_S1;
			end
			sae_pkg::ST_F_U1: begin
				cmd = sae_pkg::CMD_F_U_RD;
				state_d = sae_pkg::ST_F_U2;
			end
			sae_pkg::ST_F_U2: begin
				cmd = sae_pkg::CMD_F_U_EVAL;
				if (!st.v_zero) state_d = sae_pkg::ST_F_U3;
				else state_d = st.u_last ? sae_pkg::ST_RESP : sae_pkg::ST_F_U1;
			end
			sae_pkg::ST_F_U3: begin
				cmd = sae_pkg::CMD_F_U_OCC;
				state_d = sae_pkg::ST_F_U4;
			end
			sae_pkg::ST_F_U4: begin
				cmd = sae_pkg::CMD_F_U_WR;
				state_d = st.u_last ? sae_pkg::ST_RESP : sae_pkg::ST_F_U1;
			end
			sae_pkg::ST_D_CHK: begin
				cmd = sae_pkg::CMD_D_CHK;
				state_d = st.last_tot ? sae_pkg::ST_RESP : sae_pkg::ST_D1;
			end
			sae_pkg::ST_D1: begin
				cmd = sae_pkg::CMD_D_RD;
				state_d = sae_pkg::ST_D2;
			end
			sae_pkg::ST_D2: begin
				cmd = sae_pkg::CMD_D_LINK;
				state_d = sae_pkg::ST_D3;
			end
			sae_pkg::ST_D3: begin
				cmd = sae_pkg::CMD_D_ADD;
				state_d = sae_pkg::ST_D_CHK;
			end
			sae_pkg::ST_Q1: begin
				cmd = sae_pkg::CMD_Q_STEP;
				state_d = (!st.missed && !st.sym_bad) ? sae_pkg::ST_Q2 : sae_pkg::ST_Q3;
			end
			sae_pkg::ST_Q2: begin
				cmd = sae_pkg::CMD_Q_EVAL;
				state_d = sae_pkg::ST_Q3;
			end
			sae_pkg::ST_Q3: begin
				cmd = sae_pkg::CMD_Q_OCC;
				state_d = st.last ? sae_pkg::ST_Q4 : sae_pkg::ST_IDLE;
			end
			sae_pkg::ST_Q4: begin
				cmd = sae_pkg::CMD_Q_DONE;
				state_d = sae_pkg::ST_RESP;
			end
			sae_pkg::ST_RESP: begin
				if (st.out_free) begin
					cmd = sae_pkg::CMD_RESP;
					state_d = sae_pkg::ST_IDLE;
				end
			end
			default: state_d = sae_pkg::ST_INIT;
		endcase
	end

endmodule

/* src/sae_dp.sv */
// datapath: state tables, walk registers, finalize counters and result register
module sae_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sae_pkg::cmd_t            cmd,
	output sae_pkg::dp_status_t      st,
	input  logic [sae_pkg::SYMW-1:0] symbol,
	input  logic                     pattern_end,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [sae_pkg::RW-1:0]   result_value,
	output logic                     status
);

	localparam int SW   = sae_pkg::SW;
	localparam int TW   = sae_pkg::TW;
	localparam int LW   = sae_pkg::LW;
	localparam int KW   = sae_pkg::KW;
	localparam int HAW  = sae_pkg::HAW;
	localparam int TRAW = $clog2(sae_pkg::TR_DEPTH);

	// ram ports
	logic            tr_we, len_we, lnk_we, occ_we, end_we, h_we, so_we;
	logic [TRAW-1:0] tr_wa, tr_ra;
	logic [SW-1:0]   tr_wd, tr_rd;
	logic [SW-1:0]   len_wa, len_ra, lnk_wa, lnk_ra, occ_wa, occ_ra, end_wa, end_ra;
	logic [SW-1:0]   so_wa, so_ra;
	logic [LW-1:0]   len_wd, len_rd, occ_wd, occ_rd;
	logic [SW-1:0]   lnk_wd, lnk_rd, so_wd, so_rd;
	logic            end_wd, end_rd;
	logic [HAW-1:0]  h_wa, h_ra;
	logic [TW-1:0]   h_wd, h_rd;

	// control and walk registers
	logic [TW-1:0]          tot_q, i_q, psum_q;
	logic [SW-1:0]          wts_q, cur_q, p_q, q_q, cl_q, cursor_q, linkv_q;
	logic [LW-1:0]          wlen_q, lenp_q, lenr_q, occv_q;
	logic [KW-1:0]          k_q;
	logic [sae_pkg::SYMW-1:0] c_q;
	logic                   last_q, missed_q;
	logic [sae_pkg::RW-1:0] sum_q, res_value_q;
	logic                   res_status_q;
	logic                   out_valid_q;
	logic [sae_pkg::RW-1:0] out_value_q;
	logic                   out_status_q;

	logic [TW-1:0] slot;
	logic [LW-1:0] diff;

	assign slot = h_rd - TW'(1);
	assign diff = lenr_q - len_rd;

	sae_ram #(.WIDTH(SW), .DEPTH(sae_pkg::TR_DEPTH)) u_tr (
		.clk(clk), .we(tr_we), .waddr(tr_wa), .wdata(tr_wd), .raddr(tr_ra), .rdata(tr_rd));
	sae_ram #(.WIDTH(LW), .DEPTH(sae_pkg::STATE_CAP)) u_len (
		.clk(clk), .we(len_we), .waddr(len_wa), .wdata(len_wd), .raddr(len_ra), .rdata(len_rd));
	sae_ram #(.WIDTH(SW), .DEPTH(sae_pkg::STATE_CAP)) u_lnk (
		.clk(clk), .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(lnk_ra), .rdata(lnk_rd));
	sae_ram #(.WIDTH(LW), .DEPTH(sae_pkg::STATE_CAP)) u_occ (
		.clk(clk), .we(occ_we), .waddr(occ_wa), .wdata(occ_wd), .raddr(occ_ra), .rdata(occ_rd));
	sae_ram #(.WIDTH(1), .DEPTH(sae_pkg::STATE_CAP)) u_end (
		.clk(clk), .we(end_we), .waddr(end_wa), .wdata(end_wd), .raddr(end_ra), .rdata(end_rd));
	sae_ram #(.WIDTH(TW), .DEPTH(sae_pkg::H_DEPTH)) u_hist (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
	sae_ram #(.WIDTH(SW), .DEPTH(sae_pkg::STATE_CAP)) u_sort (
		.clk(clk), .we(so_we), .waddr(so_wa), .wdata(so_wd), .raddr(so_ra), .rdata(so_rd));

	// status back to the controller
	always_comb begin
		st.k_last    = (k_q == KW'(sae_pkg::ALPHABET - 1));
		st.copy_done = (k_q == KW'(sae_pkg::ALPHABET));
		st.sym_bad   = ({1'b0, c_q} >= (sae_pkg::SYMW + 1)'(sae_pkg::ALPHABET));
		st.full      = (wlen_q >= LW'(sae_pkg::MAX_TEXT)) ||
		               ((TW + 1)'(tot_q) + (TW + 1)'(2) > (TW + 1)'(sae_pkg::STATE_CAP));
		st.t_zero    = (tr_rd == '0);
		st.p_zero    = (p_q == '0);
		st.solid     = (len_rd == lenp_q + LW'(1));
		st.hit       = (tr_rd == q_q);
		st.at_top    = (i_q == TW'(wlen_q));
		st.last_tot  = (i_q + TW'(1) == tot_q);
		st.v_zero    = (so_rd == '0);
		st.u_last    = (i_q == TW'(1));
		st.missed    = missed_q;
		st.last      = last_q;
		st.out_free  = !out_valid_q || !out_stall;
	end

	// memory addressing per command
	always_comb begin
		tr_we = 1'b0; tr_wa = '0; tr_wd = '0; tr_ra = '0;
		len_we = 1'b0; len_wa = '0; len_wd = '0; len_ra = '0;
		lnk_we = 1'b0; lnk_wa = '0; lnk_wd = '0; lnk_ra = '0;
		occ_we = 1'b0; occ_wa = '0; occ_wd = '0; occ_ra = '0;
		end_we = 1'b0; end_wa = '0; end_wd = 1'b0; end_ra = '0;
		h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
		so_we = 1'b0; so_wa = '0; so_wd = '0; so_ra = '0;
		case (cmd)
			sae_pkg::CMD_CLR_ZERO: begin
				tr_we = 1'b1; tr_wa = {SW'(0), k_q};
				len_we = 1'b1; lnk_we = 1'b1; occ_we = 1'b1; end_we = 1'b1;
			end
			sae_pkg::CMD_APP_CHK: begin
				if (!st.sym_bad && !st.full) begin
					len_we = 1'b1; len_wa = tot_q[SW-1:0]; len_wd = wlen_q + LW'(1);
					occ_we = 1'b1; occ_wa = tot_q[SW-1:0]; occ_wd = LW'(1);
					end_we = 1'b1; end_wa = tot_q[SW-1:0]; end_wd = 1'b1;
				end
			end
			sae_pkg::CMD_APP_ZERO: begin
				tr_we = 1'b1; tr_wa = {cur_q, k_q};
			end
			sae_pkg::CMD_W_RD, sae_pkg::CMD_R_RD: begin
				tr_ra = {p_q, c_q}; lnk_ra = p_q; len_ra = p_q;
			end
			sae_pkg::CMD_W_EVAL: begin
				if (st.t_zero) begin
					tr_we = 1'b1; tr_wa = {p_q, c_q}; tr_wd = cur_q;
					if (st.p_zero) begin
						lnk_we = 1'b1; lnk_wa = cur_q;
					end
				end else begin
					len_ra = tr_rd; lnk_ra = tr_rd;
				end
			end
			sae_pkg::CMD_W_LEN: begin
				if (st.solid) begin
					lnk_we = 1'b1; lnk_wa = cur_q; lnk_wd = q_q;
				end else begin
					len_we = 1'b1; len_wa = tot_q[SW-1:0]; len_wd = lenp_q + LW'(1);
					occ_we = 1'b1; occ_wa = tot_q[SW-1:0];
					end_we = 1'b1; end_wa = tot_q[SW-1:0];
					lnk_we = 1'b1; lnk_wa = tot_q[SW-1:0]; lnk_wd = lnk_rd;
				end
			end
			sae_pkg::CMD_COPY: begin
				// read entry k of the source row, write entry k-1 of the clone
				tr_ra = {q_q, k_q};
				if (k_q != '0) begin
					tr_we = 1'b1; tr_wa = {cl_q, k_q - KW'(1)}; tr_wd = tr_rd;
				end
			end
			sae_pkg::CMD_R_EVAL: begin
				if (st.hit) begin
					tr_we = 1'b1; tr_wa = {p_q, c_q}; tr_wd = cl_q;
				end
			end
			sae_pkg::CMD_LINK_Q: begin
				lnk_we = 1'b1; lnk_wa = q_q; lnk_wd = cl_q;
			end
			sae_pkg::CMD_LINK_CUR: begin
				lnk_we = 1'b1; lnk_wa = cur_q; lnk_wd = cl_q;
			end
			sae_pkg::CMD_F_HCLR: begin
				h_we = 1'b1; h_wa = i_q[HAW-1:0];
			end
			sae_pkg::CMD_F_A_RD, sae_pkg::CMD_F_S_RD: begin
				len_ra = i_q[SW-1:0]; end_ra = i_q[SW-1:0];
			end
			sae_pkg::CMD_F_A_HRD: begin
				occ_we = 1'b1; occ_wa = i_q[SW-1:0]; occ_wd = LW'(end_rd);
				h_ra = len_rd[HAW-1:0];
			end
			sae_pkg::CMD_F_A_HWR: begin
				h_we = 1'b1; h_wa = lenr_q[HAW-1:0]; h_wd = h_rd + TW'(1);
			end
			sae_pkg::CMD_F_P_RD: begin
				h_ra = i_q[HAW-1:0];
			end
			sae_pkg::CMD_F_P_WR: begin
				h_we = 1'b1; h_wa = i_q[HAW-1:0]; h_wd = psum_q + h_rd;
			end
			sae_pkg::CMD_F_S_HRD: begin
				h_ra = len_rd[HAW-1:0];
			end
			sae_pkg::CMD_F_S_WR: begin
				h_we = 1'b1; h_wa = lenr_q[HAW-1:0]; h_wd = slot;
				so_we = 1'b1; so_wa = slot[SW-1:0]; so_wd = i_q[SW-1:0];
			end
			sae_pkg::CMD_F_U_RD: begin
				so_ra = SW'(i_q - TW'(1));
			end
			sae_pkg::CMD_F_U_EVAL: begin
				lnk_ra = so_rd; occ_ra = so_rd;
			end
			sae_pkg::CMD_F_U_OCC: begin
				occ_ra = lnk_rd;
			end
			sae_pkg::CMD_F_U_WR: begin
				occ_we = 1'b1; occ_wa = linkv_q; occ_wd = occ_rd + occv_q;
			end
			sae_pkg::CMD_D_RD: begin
				len_ra = i_q[SW-1:0]; lnk_ra = i_q[SW-1:0];
			end
			sae_pkg::CMD_D_LINK: begin
				len_ra = lnk_rd;
			end
			sae_pkg::CMD_Q_STEP: begin
				tr_ra = {cursor_q, c_q};
			end
			sae_pkg::CMD_Q_OCC: begin
				occ_ra = cursor_q;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q       <= TW'(1);
			wts_q       <= '0;
			wlen_q      <= '0;
			cursor_q    <= '0;
			missed_q    <= 1'b0;
			k_q         <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd)
				sae_pkg::CMD_ACCEPT: begin
					i_q <= '0;
				end
				sae_pkg::CMD_CLR_ZERO: begin
					tot_q    <= TW'(1);
					wts_q    <= '0;
					wlen_q   <= '0;
					cursor_q <= '0;
					missed_q <= 1'b0;
					k_q      <= st.k_last ? '0 : k_q + KW'(1);
				end
				sae_pkg::CMD_APP_CHK: begin
					if (!st.sym_bad && !st.full) begin
						tot_q <= tot_q + TW'(1);
						k_q   <= '0;
					end
				end
				sae_pkg::CMD_APP_ZERO: begin
					k_q <= st.k_last ? '0 : k_q + KW'(1);
				end
				sae_pkg::CMD_W_EVAL: begin
					if (st.t_zero && st.p_zero) begin
						wts_q  <= cur_q;
						wlen_q <= wlen_q + LW'(1);
					end
				end
				sae_pkg::CMD_W_LEN: begin
					if (st.solid) begin
						wts_q  <= cur_q;
						wlen_q <= wlen_q + LW'(1);
					end else begin
						tot_q <= tot_q + TW'(1);
						k_q   <= '0;
					end
				end
				sae_pkg::CMD_COPY: begin
					k_q <= st.copy_done ? '0 : k_q + KW'(1);
				end
				sae_pkg::CMD_LINK_CUR: begin
					wts_q  <= cur_q;
					wlen_q <= wlen_q + LW'(1);
				end
				sae_pkg::CMD_F_HCLR, sae_pkg::CMD_F_P_WR: begin
					i_q <= st.at_top ? '0 : i_q + TW'(1);
				end
				sae_pkg::CMD_F_A_HWR: begin
					i_q <= st.last_tot ? '0 : i_q + TW'(1);
				end
				sae_pkg::CMD_F_S_WR: begin
					i_q <= st.last_tot ? tot_q : i_q + TW'(1);
				end
				sae_pkg::CMD_F_U_EVAL: begin
					if (st.v_zero) i_q <= i_q - TW'(1);
				end
				sae_pkg::CMD_F_U_WR: begin
					i_q <= i_q - TW'(1);
				end
				sae_pkg::CMD_D_CHK: begin
					if (!st.last_tot) i_q <= i_q + TW'(1);
				end
				sae_pkg::CMD_Q_STEP: begin
					if (!missed_q && st.sym_bad) missed_q <= 1'b1;
				end
				sae_pkg::CMD_Q_EVAL: begin
					if (st.t_zero) missed_q <= 1'b1;
					else cursor_q <= tr_rd;
				end
				sae_pkg::CMD_Q_DONE: begin
					cursor_q <= '0;
					missed_q <= 1'b0;
				end
				default: ;
			endcase
			if (cmd == sae_pkg::CMD_RESP) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd)
			sae_pkg::CMD_ACCEPT: begin
				c_q          <= symbol;
				last_q       <= pattern_end;
				res_value_q  <= '0;
				res_status_q <= 1'b0;
				sum_q        <= '0;
			end
			sae_pkg::CMD_APP_CHK: begin
				if (!st.sym_bad && st.full) res_status_q <= 1'b1;
				cur_q <= tot_q[SW-1:0];
				p_q   <= wts_q;
			end
			sae_pkg::CMD_W_EVAL: begin
				if (st.t_zero) begin
					p_q <= lnk_rd;
				end else begin
					q_q    <= tr_rd;
					lenp_q <= len_rd;
				end
			end
			sae_pkg::CMD_W_LEN: begin
				cl_q <= tot_q[SW-1:0];
			end
			sae_pkg::CMD_R_EVAL: begin
				p_q <= lnk_rd;
			end
			sae_pkg::CMD_F_A_HRD, sae_pkg::CMD_F_S_HRD: begin
				lenr_q <= len_rd;
			end
			sae_pkg::CMD_F_A_HWR: begin
				psum_q <= '0;
			end
			sae_pkg::CMD_F_P_WR: begin
				psum_q <= psum_q + h_rd;
			end
			sae_pkg::CMD_F_U_OCC: begin
				linkv_q <= lnk_rd;
				occv_q  <= occ_rd;
			end
			sae_pkg::CMD_D_CHK: begin
				if (st.last_tot) res_value_q <= sum_q;
			end
			sae_pkg::CMD_D_LINK: begin
				lenr_q <= len_rd;
			end
			sae_pkg::CMD_D_ADD: begin
				sum_q <= sum_q + sae_pkg::RW'(diff);
			end
			sae_pkg::CMD_Q_DONE: begin
				res_value_q <= missed_q ? '0 : sae_pkg::RW'(occ_rd);
			end
			sae_pkg::CMD_RESP: begin
				out_value_q  <= res_value_q;
				out_status_q <= res_status_q;
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign status       = out_status_q;

`ifndef NO_ASSERTIONS
	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == sae_pkg::CMD_RESP) |-> !(out_valid_q && out_stall))
		else $error("result register loaded while a result waits");

	// a successful append allocates exactly one state first
	a_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == sae_pkg::CMD_APP_CHK && !st.sym_bad && !st.full)
		|=> (tot_q == $past(tot_q) + TW'(1)))
		else $error("append did not allocate a state");

	// there is always more states than text symbols
	a_tot_len: assert property (@(posedge clk) disable iff (!arst_n)
		(TW'(wlen_q) < tot_q) && (tot_q <= TW'(sae_pkg::STATE_CAP)))
		else $error("state total out of step with text length");
`endif

endmodule

/* src/suffix_automaton_engine.sv */
// top level of the suffix automaton engine: controller and datapath
//
// channel   direction  handshake           payload
// in        in         in_valid/in_stall   operation, symbol, pattern_end
// out       out        out_valid/out_stall result_value, status
//
// one request at a time, taken only in the idle state
// append: walks suffix links (the walk may end at the root), or is rejected
// a clone redirects transitions to itself; distinct visits every non-root state
// finalize: passes over the text lengths and the states through the histogram ram
// after reset the root row is zeroed before the first request
// a result waits in the output register while the next request is taken
module suffix_automaton_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [sae_pkg::OPW-1:0]   operation,
	input  logic [sae_pkg::SYMW-1:0]  symbol,
	input  logic                      pattern_end,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [sae_pkg::RW-1:0]    result_value,
	output logic                      status
);

	sae_pkg::cmd_t       cmd;
	sae_pkg::dp_status_t st;

	sae_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .st(st), .cmd(cmd));

	sae_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st), .symbol(symbol),
		.pattern_end(pattern_end), .out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .status(status));

endmodule

/* tb/tb_suffix_automaton_engine.sv */
// self-checking testbench for the suffix automaton engine
`timescale 1ns / 1ps

module tb_suffix_automaton_engine;
	import sae_pkg::*;

	localparam logic [OPW-1:0] OP_SPARE_A = 3'd5;
	localparam logic [OPW-1:0] OP_SPARE_B = 3'd6;
	localparam logic [OPW-1:0] OP_SPARE_C = 3'd7;
	localparam int SYM_TOP = (1 << SYMW) - 1;

	typedef struct packed {
		logic [OPW-1:0]  op;
		logic [SYMW-1:0] sym;
		logic            last;
	} request_t;

	typedef struct packed {
		logic [RW-1:0] value;
		logic          status;
	} answer_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OPW-1:0]      operation;
	logic [SYMW-1:0]     symbol;
	logic                pattern_end;
	logic                out_valid;
	logic                out_stall;
	logic [RW-1:0]       result_value;
	logic                status;

	request_t pending_requests[$];
	answer_t  expected_answers[$];
	int       send_idle_pct;
	int       recv_stall_pct;
	int       mismatches;
	int       answers_checked;
	int       requests_sent;
	int       overflows_seen;
	int       text_written[$];

	// automaton shadow
	logic [LW-1:0] sh_len[STATE_CAP];
	logic [SW-1:0] sh_link[STATE_CAP];
	logic [SW-1:0] sh_next[STATE_CAP][ALPHABET];
	logic [LW-1:0] sh_occ[STATE_CAP];
	logic          sh_tail[STATE_CAP];
	int            sh_hist[H_DEPTH];
	int            sh_order[STATE_CAP];
	int            sh_total;
	int            sh_last;
	int            sh_cursor;
	logic          sh_missed;

	suffix_automaton_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .symbol(symbol), .pattern_end(pattern_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .status(status)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void restart_automaton();
		sh_total = 1;
		sh_last = 0;
		sh_len[0] = '0;
		sh_link[0] = '0;
		sh_occ[0] = '0;
		sh_tail[0] = 1'b0;
		for (int s = 0; s < ALPHABET; s++) sh_next[0][s] = '0;
		sh_cursor = 0;
		sh_missed = 1'b0;
	endfunction

	function automatic logic extend_text(int c);
		int cur, p, q, cl;
		bit live;
		live = 1;
		if (sh_len[sh_last] >= MAX_TEXT || sh_total + 2 > STATE_CAP) return 1'b1;
		cur = sh_total++;
		sh_len[cur] = sh_len[sh_last] + LW'(1);
		sh_occ[cur] = LW'(1);
		sh_tail[cur] = 1'b1;
		for (int s = 0; s < ALPHABET; s++) sh_next[cur][s] = '0;
		p = sh_last;
		while (live && sh_next[p][c] == 0) begin
			sh_next[p][c] = SW'(cur);
			if (p == 0) live = 0; else p = sh_link[p];
		end
		if (!live) begin
			sh_link[cur] = '0;
		end else begin
			q = sh_next[p][c];
			if (sh_len[q] == sh_len[p] + 1) begin
				sh_link[cur] = SW'(q);
			end else begin
				// split q by cloning
				cl = sh_total++;
				for (int s = 0; s < ALPHABET; s++) sh_next[cl][s] = sh_next[q][s];
				sh_link[cl] = sh_link[q];
				sh_len[cl] = sh_len[p] + LW'(1);
				sh_occ[cl] = '0;
				sh_tail[cl] = 1'b0;
				while (live && sh_next[p][c] == q) begin
					sh_next[p][c] = SW'(cl);
					if (p == 0) live = 0; else p = sh_link[p];
				end
				sh_link[q] = SW'(cl);
				sh_link[cur] = SW'(cl);
			end
		end
		sh_last = cur;
		return 1'b0;
	endfunction

	function automatic int len_bucket(int v);
		return v > MAX_TEXT ? MAX_TEXT : v;
	endfunction

	function automatic void tally_end_counts();
		int top, slot, v;
		top = len_bucket(sh_len[sh_last]);
		for (int i = 0; i < H_DEPTH; i++) sh_hist[i] = 0;
		for (int i = 0; i < sh_total; i++) begin
			sh_occ[i] = LW'(sh_tail[i]);
			sh_hist[len_bucket(sh_len[i])]++;
		end
		for (int i = 1; i <= top; i++) sh_hist[i] += sh_hist[i-1];
		for (int i = 0; i < sh_total; i++) begin
			slot = --sh_hist[len_bucket(sh_len[i])];
			if (slot >= 0 && slot < STATE_CAP) sh_order[slot] = i;
		end
		// longest first, push counts up the link tree
		for (int i = sh_total; i > 0; i--) begin
			v = sh_order[i-1];
			if (v != 0) sh_occ[sh_link[v]] = sh_occ[sh_link[v]] + sh_occ[v];
		end
	endfunction

	function automatic logic [RW-1:0] count_distinct();
		logic [RW-1:0] sum;
		sum = '0;
		for (int i = 1; i < sh_total; i++)
			sum = sum + RW'(sh_len[i] - sh_len[sh_link[i]]);
		return sum;
	endfunction

	function automatic void predict_answer(request_t rq);
		answer_t a;
		a = '0;
		case (rq.op)
			OP_CLEAR: restart_automaton();
			OP_APPEND: begin
				if (rq.sym < ALPHABET) a.status = extend_text(rq.sym);
			end
			OP_FINALIZE: tally_end_counts();
			OP_DISTINCT: a.value = count_distinct();
			OP_QUERY: begin
				if (!sh_missed) begin
					if (rq.sym >= ALPHABET || sh_next[sh_cursor][rq.sym] == 0)
						sh_missed = 1'b1;
					else
						sh_cursor = sh_next[sh_cursor][rq.sym];
				end
				if (!rq.last) return;
				a.value = sh_missed ? '0 : RW'(sh_occ[sh_cursor]);
				sh_cursor = 0;
				sh_missed = 1'b0;
			end
			default: return;
		endcase
		expected_answers.insert(expected_answers.size(), a);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= '0;
			symbol <= '0;
			pattern_end <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_answer('{operation, symbol, pattern_end});
				requests_sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					request_t rq;
					rq = pending_requests.pop_front();
					in_valid <= 1'b1;
					operation <= rq.op;
					symbol <= rq.sym;
					pattern_end <= rq.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: value %0d status %0d",
							result_value, status);
				end else begin
					answer_t a;
					a = expected_answers.pop_front();
					answers_checked++;
					if (status) overflows_seen++;
					if (a.value !== result_value || a.status !== status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch at result %0d: expected %0d/%0d got %0d/%0d",
								answers_checked, a.value, a.status, result_value, status);
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic put(logic [OPW-1:0] op, int sym, bit last);
		request_t rq;
		rq.op = op;
		rq.sym = sym[SYMW-1:0];
		rq.last = last;
		pending_requests.insert(pending_requests.size(), rq);
		if (op == OP_CLEAR) text_written.delete();
		if (op == OP_APPEND && sym < ALPHABET) text_written.insert(text_written.size(), sym);
	endtask

	task automatic drain();
		while (pending_requests.size() > 0 || in_valid || expected_answers.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// one session: clear, text, finalize, distinct, then mostly real substrings as patterns
	task automatic put_session(int n_app, int span);
		int st, ln;
		put(OP_CLEAR, $urandom_range(SYM_TOP), $urandom_range(1));
		for (int i = 0; i < n_app; i++)
			put(OP_APPEND, ($urandom_range(19) == 0) ? $urandom_range(SYM_TOP)
				: $urandom_range(span - 1), $urandom_range(1));
		if ($urandom_range(3) == 0) begin
			put(OP_QUERY, $urandom_range(span - 1), 1'b1);
		end
		put(OP_FINALIZE, $urandom_range(SYM_TOP), $urandom_range(1));
		put(OP_DISTINCT, $urandom_range(SYM_TOP), $urandom_range(1));
		for (int k = 0; k < 6; k++) begin
			if (text_written.size() > 0 && $urandom_range(3) != 0) begin
				st = $urandom_range(text_written.size() - 1);
				ln = $urandom_range(text_written.size() - st);
				if (ln == 0) ln = 1;
				for (int j = 0; j < ln; j++)
					put(OP_QUERY, text_written[st + j], j == ln - 1);
			end else begin
				ln = $urandom_range(1, 3);
				for (int j = 0; j < ln; j++)
					put(OP_QUERY, ($urandom_range(9) == 0) ? $urandom_range(SYM_TOP)
						: $urandom_range(span - 1), j == ln - 1);
			end
		end
		// noise
		if ($urandom_range(4) == 0)
			put(OPW'(OP_SPARE_A + $urandom_range(2)), $urandom_range(SYM_TOP), 1);
		if ($urandom_range(4) == 0) put(OP_APPEND, $urandom_range(span - 1), 0);
		if ($urandom_range(4) == 0) put(OP_DISTINCT, 0, 0);
	endtask

	initial begin
		int idle_send[4];
		int idle_recv[4];
		int quota;
		idle_send = '{0, 69, 0, 12};
		idle_recv = '{0, 0, 69, 12};
		mismatches = 0;
		answers_checked = 0;
		requests_sent = 0;
		overflows_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		in_valid = 1'b0;
		operation = '0;
		symbol = '0;
		pattern_end = 1'b0;
		out_stall = 1'b0;
		restart_automaton();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners
		put(OP_QUERY, 0, 1'b1);
		put(OP_DISTINCT, 0, 1'b0);
		put(OP_APPEND, 0, 1'b0);
		put(OP_APPEND, 31, 1'b1);
		put(OP_APPEND, 26, 1'b0);
		put(OP_APPEND, 25, 1'b0);
		put(OP_APPEND, 0, 1'b0);
		put(OP_QUERY, 0, 1'b1);
		put(OP_FINALIZE, 0, 1'b0);
		put(OP_QUERY, 0, 1'b1);
		put(OP_FINALIZE, 31, 1'b1);
		put(OP_QUERY, 0, 1'b0);
		put(OP_QUERY, 25, 1'b1);
		put(OP_QUERY, 31, 1'b0);
		put(OP_QUERY, 0, 1'b1);
		put(OP_DISTINCT, 31, 1'b1);
		put(OP_SPARE_A, 0, 1'b0);
		put(OP_SPARE_B, 31, 1'b1);
		put(OP_SPARE_C, 16, 1'b1);
		put(OP_APPEND, 0, 1'b0);
		put(OP_QUERY, 0, 1'b1);
		put(OP_CLEAR, 0, 1'b0);
		put(OP_QUERY, 0, 1'b1);
		put(OP_DISTINCT, 0, 1'b0);
		drain();

		// random sessions over the idling mixes
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_send[ph];
			recv_stall_pct = idle_recv[ph];
			quota = requests_sent + 310;
			while (requests_sent + pending_requests.size() < quota)
				put_session($urandom_range(1, 24), ($urandom_range(2) == 0) ? 2
					: $urandom_range(2, ALPHABET));
			drain();
		end

		$display("checked %0d results from %0d requests, %0d capacity rejections",
			answers_checked, requests_sent, overflows_seen);
		$display("covered four idle and stall mixes over short random texts and patterns");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

/* files.f */
src/sae_pkg.sv
src/sae_ram.sv
src/sae_ctrl.sv
src/sae_dp.sv
src/suffix_automaton_engine.sv
tb/tb_suffix_automaton_engine.sv
